FILE: sv/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// types, codes and constants shared by the bank mapper modules
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int WORK_RAM_BYTES_DEF = 8192;

    localparam logic [2:0] OP_CPU_RD  = 3'd0;
    localparam logic [2:0] OP_CPU_WR  = 3'd1;
    localparam logic [2:0] OP_VID_RD  = 3'd2;
    localparam logic [2:0] OP_VID_WR  = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_RAM    = 3'd1;
    localparam logic [2:0] KIND_PRG    = 3'd2;
    localparam logic [2:0] KIND_CHR    = 3'd3;
    localparam logic [2:0] KIND_CHR_WR = 3'd4;

    localparam logic [1:0] REG_PRG_UNITS = 2'd0;
    localparam logic [1:0] REG_CHR_UNITS = 2'd1;
    localparam logic [1:0] REG_CHR_RAM   = 2'd2;
    localparam logic [1:0] REG_HDR_MIRR  = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] address;
        logic [7:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  read_data;
        logic [20:0] mem_address;
        logic [7:0]  mem_write_data;
        logic        irq;
        logic        mirroring;
    } out_item_t;

    // request to the shared modulo unit
    typedef struct packed {
        logic        start;
        logic [7:0]  dividend;
        logic [11:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic        done;
        logic [7:0]  remainder;
    } mod_rsp_t;

endpackage

FILE: sv/cbm_ram.sv
// ----------------------------------------------------------------------------
// cbm_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        rd_data <= mem[addr];
    end
endmodule

FILE: sv/cbm_mod.sv
// ----------------------------------------------------------------------------
// cbm_mod
// shared remainder unit, restoring shift-subtract, one bit per cycle
// ----------------------------------------------------------------------------
module cbm_mod (
    input  logic              aclk,
    input  logic              aresetn,
    input  cbm_pkg::mod_req_t req,
    output cbm_pkg::mod_rsp_t rsp
);
    import cbm_pkg::*;

    logic [7:0]  quo_reg, quo_next;
    logic [11:0] rem_reg, rem_next;
    logic [11:0] div_reg, div_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [12:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[7]} - {1'b0, div_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
            cnt_next  = 4'd8;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[6:0], 1'b0};
            if (!trial[12]) begin
                rem_next = trial[11:0];
            end else begin
                rem_next = {rem_reg[10:0], quo_reg[7]};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[7:0];

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |=> !rsp.done) else $error("done held");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg)) else $error("done without busy");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done && div_reg != '0 |-> rem_reg < div_reg) else $error("remainder range");
endmodule

FILE: sv/cartridge_bank_mapper_with_line_irq.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_line_irq
// bank-switching mapper with work ram and scanline interrupt counter
// ----------------------------------------------------------------------------
// One item in flight at a time. Accesses without a bank lookup pass through
// the ram, decode and finish states; prg reads and banked chr reads also wait
// on the 8-step shared remainder unit reducing the bank number by the bank count.
// s_ready is low from acceptance until the result has been taken.
module cartridge_bank_mapper_with_line_irq #(
    parameter int WORK_RAM_BYTES = cbm_pkg::WORK_RAM_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cbm_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cbm_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data
);
    import cbm_pkg::*;

    localparam int RAW = $clog2(WORK_RAM_BYTES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RAM  = 3'd1;
    localparam logic [2:0] ST_DEC  = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  st_reg, st_next;
    in_item_t    it_reg;
    out_item_t   res_reg, res_next;
    logic [5:0]  prg_units_reg;
    logic [8:0]  chr_units_reg;
    logic        chr_ram_reg, hdr_mirr_reg;
    logic [2:0]  bidx_reg, bidx_next;
    logic        pswap_reg, pswap_next, cswap_reg, cswap_next;
    logic [7:0]  bank_reg [8];
    logic [7:0]  bank_next [8];
    logic [7:0]  latch_reg, latch_next, cnt_reg, cnt_next;
    logic        reload_reg, reload_next, irqen_reg, irqen_next;
    logic        irq_reg, irq_next, mirr_reg, mirr_next;
    logic        fixed_reg, fixed_next;
    logic [6:0]  fixbank_reg, fixbank_next;
    mod_req_t    mreq;
    mod_rsp_t    mrsp;
    logic        ram_we;
    logic [7:0]  ram_q;
    logic        take;

    logic [15:0] a;
    logic [6:0]  pcount;
    logic [2:0]  slot;
    logic [7:0]  cv;

    assign take      = s_valid && s_ready;
    assign s_ready   = st_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_valid   = st_reg == ST_OUT;
    assign m_data    = res_reg;
    assign a         = it_reg.address;
    assign pcount    = (prg_units_reg == '0) ? 7'd2 : {prg_units_reg, 1'b0};
    assign ram_we    = st_reg == ST_DEC && it_reg.operation == OP_CPU_WR
                       && a[15:13] == 3'b011;

    cbm_ram #(.WIDTH(8), .DEPTH(WORK_RAM_BYTES)) u_ram (
        .aclk(aclk), .wr_en(ram_we), .addr(a[RAW-1:0]),
        .wr_data(it_reg.write_data), .rd_data(ram_q)
    );

    cbm_mod u_mod (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));

    always_comb begin
        slot = a[12:10] ^ {cswap_reg, 2'b00};
        unique case (slot)
            3'd0:    cv = bank_reg[0] & 8'hFE;
            3'd1:    cv = bank_reg[0] | 8'h01;
            3'd2:    cv = bank_reg[1] & 8'hFE;
            3'd3:    cv = bank_reg[1] | 8'h01;
            default: cv = bank_reg[{1'b0, slot[1:0]} + 3'd2];
        endcase
    end

    always_comb begin
        st_next      = st_reg;
        res_next     = res_reg;
        bidx_next    = bidx_reg;
        pswap_next   = pswap_reg;
        cswap_next   = cswap_reg;
        bank_next    = bank_reg;
        latch_next   = latch_reg;
        cnt_next     = cnt_reg;
        reload_next  = reload_reg;
        irqen_next   = irqen_reg;
        irq_next     = irq_reg;
        mirr_next    = mirr_reg;
        fixed_next   = fixed_reg;
        fixbank_next = fixbank_reg;
        mreq         = '0;
        unique case (st_reg)
            ST_IDLE: begin
                if (take) begin
                    st_next = ST_RAM;
                end
            end
            ST_RAM: begin
                st_next = ST_DEC;
            end
            ST_DEC: begin
                res_next = '0;
                st_next  = ST_FIN;
                unique case (it_reg.operation)
                    OP_CPU_RD: begin
                        if (a[15:13] == 3'b011) begin
                            res_next.kind      = KIND_RAM;
                            res_next.read_data = ram_q;
                        end else if (a[15]) begin
                            res_next.kind = KIND_PRG;
                            fixed_next    = 1'b0;
                            mreq.start    = 1'b1;
                            mreq.divisor  = {5'd0, pcount};
                            st_next       = ST_MOD;
                            if (a[14:13] == 2'd3) begin
                                fixed_next   = 1'b1;
                                fixbank_next = pcount - 7'd1;
                            end else if (a[14:13] == 2'd1) begin
                                mreq.dividend = bank_reg[7];
                            end else if ((a[14:13] == 2'd0) == pswap_reg) begin
                                fixed_next   = 1'b1;
                                fixbank_next = pcount - 7'd2;
                            end else begin
                                mreq.dividend = bank_reg[6];
                            end
                        end
                    end
                    OP_CPU_WR: begin
                        if (a[15]) begin
                            unique case (a[14:13])
                                2'd0: begin
                                    if (!a[0]) begin
                                        bidx_next  = it_reg.write_data[2:0];
                                        pswap_next = it_reg.write_data[6];
                                        cswap_next = it_reg.write_data[7];
                                    end else begin
                                        bank_next[bidx_reg] = it_reg.write_data;
                                    end
                                end
                                2'd1: begin
                                    if (!a[0]) mirr_next = it_reg.write_data[0];
                                end
                                2'd2: begin
                                    if (!a[0]) begin
                                        latch_next = it_reg.write_data;
                                    end else begin
                                        cnt_next    = '0;
                                        reload_next = 1'b1;
                                    end
                                end
                                default: begin
                                    if (!a[0]) begin
                                        irqen_next = 1'b0;
                                        irq_next   = 1'b0;
                                    end else begin
                                        irqen_next = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    OP_VID_RD: begin
                        if (a[15:13] == 3'b000) begin
                            res_next.kind = KIND_CHR;
                            if (chr_units_reg == '0 || chr_ram_reg) begin
                                res_next.mem_address = {8'd0, a[12:0]};
                            end else begin
                                fixed_next    = 1'b0;
                                mreq.start    = 1'b1;
                                mreq.dividend = cv;
                                mreq.divisor  = {chr_units_reg, 3'b000};
                                st_next       = ST_MOD;
                            end
                        end
                    end
                    OP_VID_WR: begin
                        if (a[15:13] == 3'b000 && chr_ram_reg) begin
                            res_next.kind           = KIND_CHR_WR;
                            res_next.mem_address    = {8'd0, a[12:0]};
                            res_next.mem_write_data = it_reg.write_data;
                        end
                    end
                    OP_TICK: begin
                        if (cnt_reg == '0 || reload_reg) begin
                            cnt_next    = latch_reg;
                            reload_next = 1'b0;
                        end else begin
                            cnt_next = cnt_reg - 8'd1;
                        end
                        if (cnt_next == '0 && irqen_reg) irq_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_MOD: begin
                if (mrsp.done) begin
                    st_next = ST_FIN;
                    if (res_reg.kind == KIND_PRG) begin
                        res_next.mem_address = fixed_reg
                            ? {1'b0, fixbank_reg, a[12:0]}
                            : {mrsp.remainder, a[12:0]};
                    end else begin
                        res_next.mem_address = {3'd0, mrsp.remainder, a[9:0]};
                    end
                end
            end
            ST_FIN: begin
                res_next.irq       = irq_reg;
                res_next.mirroring = mirr_reg;
                st_next            = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            bidx_reg      <= '0;
            pswap_reg     <= 1'b0;
            cswap_reg     <= 1'b0;
            latch_reg     <= '0;
            cnt_reg       <= '0;
            reload_reg    <= 1'b0;
            irqen_reg     <= 1'b0;
            irq_reg       <= 1'b0;
            mirr_reg      <= hdr_mirr_reg;
            for (int i = 0; i < 8; i++) bank_reg[i] <= '0;
        end else begin
            st_reg     <= st_next;
            bidx_reg   <= bidx_next;
            pswap_reg  <= pswap_next;
            cswap_reg  <= cswap_next;
            latch_reg  <= latch_next;
            cnt_reg    <= cnt_next;
            reload_reg <= reload_next;
            irqen_reg  <= irqen_next;
            irq_reg    <= irq_next;
            mirr_reg   <= mirr_next;
            bank_reg   <= bank_next;
        end
        if (take) it_reg <= s_data;
        res_reg     <= res_next;
        fixed_reg   <= fixed_next;
        fixbank_reg <= fixbank_next;
    end

    // config registers keep their value across reset release except by write;
    // reset loads the defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_units_reg <= 6'd2;
            chr_units_reg <= '0;
            chr_ram_reg   <= 1'b0;
            hdr_mirr_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PRG_UNITS: prg_units_reg <= cfg_data[5:0];
                REG_CHR_UNITS: chr_units_reg <= cfg_data;
                REG_CHR_RAM:   chr_ram_reg   <= cfg_data[0];
                default:       hdr_mirr_reg  <= cfg_data[0];
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_irq_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !irqen_reg && $past(st_reg == ST_DEC) |-> !irq_reg || $past(irq_reg))
        else $error("irq set while disabled");
endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bank mapper with scanline interrupt
// ----------------------------------------------------------------------------
// Bus events are driven through the valid/ready input channel. A scoreboard
// class predicts each result from its own copy of the mapper state. Every
// output field is compared in order. Runs cover several cartridge settings,
// with random idling and stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cbm_pkg::*;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int RUN_LIMIT = 600000;

    class mapper_scoreboard;
        bit [5:0]  prg_units = 6'd2;
        bit [8:0]  chr_units = 9'd0;
        bit        chr_ram   = 1'b0;
        bit        hdr_mirr  = 1'b0;
        bit [2:0]  bank_index;
        bit        prg_swap, chr_swap;
        bit [7:0]  bank_regs [8];
        bit [7:0]  line_latch, line_count;
        bit        reload_flag, irq_enable, irq_flag;
        bit        mirror_bit;
        bit [7:0]  work_ram [WORK_RAM_BYTES_DEF];
        out_item_t expected_q [$];
        int        errors;

        function void set_register(logic [1:0] idx, logic [8:0] val);
            case (idx)
                REG_PRG_UNITS: prg_units = val[5:0];
                REG_CHR_UNITS: chr_units = val;
                REG_CHR_RAM:   chr_ram   = val[0];
                REG_HDR_MIRR:  hdr_mirr  = val[0];
                default: ;
            endcase
        endfunction

        function bit [20:0] prg_offset(bit [15:0] a);
            int units, count, sw, bank;
            units = (prg_units != 0) ? prg_units : 1;
            count = units * 2;
            sw = bank_regs[6] % count;
            if (a <= 16'h9FFF)      bank = prg_swap ? count - 2 : sw;
            else if (a <= 16'hBFFF) bank = bank_regs[7] % count;
            else if (a <= 16'hDFFF) bank = prg_swap ? sw : count - 2;
            else                    bank = count - 1;
            return 21'(bank * 'h2000 + a[12:0]);
        endfunction

        function bit [20:0] chr_offset(bit [15:0] a);
            bit [2:0] slot;
            int v;
            slot = a[12:10];
            if (chr_swap) slot[2] = ~slot[2];
            case (slot)
                3'd0: v = bank_regs[0] & 8'hFE;
                3'd1: v = bank_regs[0] | 8'h01;
                3'd2: v = bank_regs[1] & 8'hFE;
                3'd3: v = bank_regs[1] | 8'h01;
                default: v = bank_regs[2 + slot - 4];
            endcase
            v = v % (chr_units * 8);
            return 21'(v * 'h400 + a[9:0]);
        endfunction

        function void cpu_store(bit [15:0] a, bit [7:0] d);
            if (a >= 16'h6000 && a <= 16'h7FFF) begin
                work_ram[a[12:0]] = d;
            end else if (a >= 16'h8000) begin
                if (a <= 16'h9FFF) begin
                    if (!a[0]) begin
                        bank_index = d[2:0];
                        prg_swap = d[6];
                        chr_swap = d[7];
                    end else begin
                        bank_regs[bank_index] = d;
                    end
                end else if (a <= 16'hBFFF) begin
                    if (!a[0]) mirror_bit = d[0];
                end else if (a <= 16'hDFFF) begin
                    if (!a[0]) begin
                        line_latch = d;
                    end else begin
                        line_count = 0;
                        reload_flag = 1;
                    end
                end else begin
                    if (!a[0]) begin
                        irq_enable = 0;
                        irq_flag = 0;
                    end else begin
                        irq_enable = 1;
                    end
                end
            end
        endfunction

        function void note_input(in_item_t it);
            out_item_t r;
            r = '0;
            case (it.operation)
                OP_CPU_RD: begin
                    if (it.address >= 16'h6000 && it.address <= 16'h7FFF) begin
                        r.kind = KIND_RAM;
                        r.read_data = work_ram[it.address[12:0]];
                    end else if (it.address >= 16'h8000) begin
                        r.kind = KIND_PRG;
                        r.mem_address = prg_offset(it.address);
                    end
                end
                OP_CPU_WR: cpu_store(it.address, it.write_data);
                OP_VID_RD: begin
                    if (it.address <= 16'h1FFF) begin
                        r.kind = KIND_CHR;
                        if (chr_units == 0 || chr_ram)
                            r.mem_address = 21'(it.address[12:0]);
                        else
                            r.mem_address = chr_offset(it.address);
                    end
                end
                OP_VID_WR: begin
                    if (it.address <= 16'h1FFF && chr_ram) begin
                        r.kind = KIND_CHR_WR;
                        r.mem_address = 21'(it.address[12:0]);
                        r.mem_write_data = it.write_data;
                    end
                end
                OP_TICK: begin
                    if (line_count == 0 || reload_flag) begin
                        line_count = line_latch;
                        reload_flag = 0;
                    end else begin
                        line_count = line_count - 8'd1;
                    end
                    if (line_count == 0 && irq_enable) irq_flag = 1;
                end
                default: ;
            endcase
            r.irq = irq_flag;
            r.mirroring = mirror_bit;
            expected_q.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.kind !== e.kind)
                $display("%0t kind exp %0d got %0d", $time, e.kind, got.kind);
            if (got.read_data !== e.read_data)
                $display("%0t read_data exp %h got %h", $time, e.read_data, got.read_data);
            if (got.mem_address !== e.mem_address)
                $display("%0t mem_address exp %h got %h", $time, e.mem_address,
                         got.mem_address);
            if (got.mem_write_data !== e.mem_write_data)
                $display("%0t mem_write_data exp %h got %h", $time, e.mem_write_data,
                         got.mem_write_data);
            if (got.irq !== e.irq)
                $display("%0t irq exp %b got %b", $time, e.irq, got.irq);
            if (got.mirroring !== e.mirroring)
                $display("%0t mirroring exp %b got %b", $time, e.mirroring, got.mirroring);
            if (got !== e) errors++;
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;

    mapper_scoreboard sb = new();
    bit  ram_written [WORK_RAM_BYTES_DEF];
    int  ram_addrs [$];
    bit  quiet;
    int  n_sent;
    int  cycles;

    cartridge_bank_mapper_with_line_irq i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("FAIL cartridge_bank_mapper_with_line_irq");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);

    // receiver: random stalls, one long hold-off, none near the end
    initial begin
        bit held;
        held = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && n_sent >= 600) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 30)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    task automatic send(bit [2:0] op, bit [15:0] a, bit [7:0] d);
        in_item_t it;
        it.operation = op;
        it.address = a;
        it.write_data = d;
        if (op == OP_CPU_WR && a >= 16'h6000 && a <= 16'h7FFF && !ram_written[a[12:0]]) begin
            ram_written[a[12:0]] = 1;
            ram_addrs.push_back(a);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        n_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic write_register(logic [1:0] idx, logic [8:0] val);
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_register(idx, val);
    endtask

    task automatic set_cartridge(int prg, int chr, bit ram, bit hdr);
        write_register(REG_PRG_UNITS, 9'(prg));
        write_register(REG_CHR_UNITS, 9'(chr));
        write_register(REG_CHR_RAM, 9'(ram));
        write_register(REG_HDR_MIRR, 9'(hdr));
    endtask

    task automatic random_item();
        int pick;
        bit [15:0] a;
        bit [7:0] d;
        pick = $urandom_range(0, 99);
        a = 16'($urandom_range(0, 16'hFFFF));
        d = 8'($urandom_range(0, 255));
        if (pick < 25) begin
            case ($urandom_range(0, 5))
                0: a = 16'($urandom_range(0, 16'h5FFF));
                1: begin
                    if (ram_addrs.size() == 0) a = {3'b011, a[12:0]};
                    else a = 16'(ram_addrs[$urandom_range(0, ram_addrs.size() - 1)]);
                    if (!ram_written[a[12:0]]) begin
                        send(OP_CPU_WR, a, d);
                        return;
                    end
                end
                default: a[15] = 1'b1;
            endcase
            send(OP_CPU_RD, a, d);
        end else if (pick < 55) begin
            case ($urandom_range(0, 9))
                0: a = 16'($urandom_range(0, 16'h5FFF));
                1, 2: a[15:13] = 3'b011;
                3: begin
                    a[15:13] = 3'b110;
                    if ($urandom_range(0, 1)) d = 8'($urandom_range(0, 7));
                end
                4: begin
                    a[15:13] = 3'b111;
                    a[0] = $urandom_range(0, 3) != 0;
                end
                default: a[15] = 1'b1;
            endcase
            send(OP_CPU_WR, a, d);
        end else if (pick < 72) begin
            if ($urandom_range(0, 7) != 0) a[15:13] = 3'b000;
            send(OP_VID_RD, a, d);
        end else if (pick < 82) begin
            if ($urandom_range(0, 7) != 0) a[15:13] = 3'b000;
            send(OP_VID_WR, a, d);
        end else if (pick < 96) begin
            send(OP_TICK, a, d);
        end else begin
            send(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), a, d);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default cartridge, register and window edges
        send(OP_CPU_RD, 16'h0000, 8'h00);
        send(OP_CPU_RD, 16'h5FFF, 8'hFF);
        send(OP_CPU_WR, 16'h0000, 8'hFF);
        send(OP_CPU_WR, 16'h6000, 8'hA5);
        send(OP_CPU_WR, 16'h7FFF, 8'hFF);
        send(OP_CPU_RD, 16'h6000, 8'h00);
        send(OP_CPU_RD, 16'h7FFF, 8'h00);
        send(OP_CPU_WR, 16'h8000, 8'hC6);
        send(OP_CPU_WR, 16'h8001, 8'hFF);
        send(OP_CPU_RD, 16'h8000, 8'h00);
        send(OP_CPU_RD, 16'h9FFF, 8'h00);
        send(OP_CPU_RD, 16'hA000, 8'h00);
        send(OP_CPU_RD, 16'hC000, 8'h00);
        send(OP_CPU_RD, 16'hFFFF, 8'h00);
        send(OP_CPU_WR, 16'hA000, 8'h01);
        send(OP_CPU_WR, 16'hA001, 8'hFF);
        send(OP_CPU_WR, 16'hC000, 8'h01);
        send(OP_CPU_WR, 16'hC001, 8'h00);
        send(OP_CPU_WR, 16'hE001, 8'h00);
        send(OP_TICK, 16'h0000, 8'h00);
        send(OP_TICK, 16'hFFFF, 8'hFF);
        send(OP_VID_RD, 16'h1FFF, 8'h00);
        send(OP_VID_RD, 16'h2000, 8'h00);
        send(OP_VID_WR, 16'h1FFF, 8'h5A);
        send(OP_SPARE_LAST, 16'h8000, 8'hFF);
        send(OP_CPU_WR, 16'hE000, 8'h00);

        set_cartridge(32, 256, 0, 1);
        repeat (300) random_item();
        set_cartridge(1, 1, 0, 0);
        repeat (300) random_item();
        set_cartridge(0, 16, 1, 1);
        repeat (250) random_item();
        set_cartridge(3, 255, 0, 0);
        repeat (300) random_item();
        set_cartridge($urandom_range(1, 32), $urandom_range(0, 256),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat (350) random_item();
        quiet = 1;
        set_cartridge(5, 3, 0, 1);
        repeat (250) random_item();

        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS cartridge_bank_mapper_with_line_irq");
        else
            $display("FAIL cartridge_bank_mapper_with_line_irq");
        $finish;
    end
endmodule

FILE: sim.f
sv/cbm_pkg.sv
sv/cbm_ram.sv
sv/cbm_mod.sv
sv/cartridge_bank_mapper_with_line_irq.sv
tb/tb_top.sv
